### hw/rtl/y86_isd_pkg.sv
package y86_isd_pkg;

  // Opcodes of the extended instruction set (code in high nibble, function in low).
  localparam logic [7:0] OpNop    = 8'h00;
  localparam logic [7:0] OpHalt   = 8'h10;
  localparam logic [7:0] OpRrmovl = 8'h20;
  localparam logic [7:0] OpIrmovl = 8'h30;
  localparam logic [7:0] OpRmmovl = 8'h40;
  localparam logic [7:0] OpMrmovl = 8'h50;
  localparam logic [7:0] OpAddl   = 8'h60;
  localparam logic [7:0] OpSubl   = 8'h61;
  localparam logic [7:0] OpAndl   = 8'h62;
  localparam logic [7:0] OpXorl   = 8'h63;
  localparam logic [7:0] OpAlu4   = 8'h64;
  localparam logic [7:0] OpAlu5   = 8'h65;
  localparam logic [7:0] OpJmp    = 8'h70;
  localparam logic [7:0] OpJle    = 8'h71;
  localparam logic [7:0] OpJl     = 8'h72;
  localparam logic [7:0] OpJe     = 8'h73;
  localparam logic [7:0] OpJne    = 8'h74;
  localparam logic [7:0] OpJge    = 8'h75;
  localparam logic [7:0] OpJg     = 8'h76;
  localparam logic [7:0] OpCall   = 8'h80;
  localparam logic [7:0] OpRet    = 8'h90;
  localparam logic [7:0] OpPushl  = 8'ha0;
  localparam logic [7:0] OpPopl   = 8'hb0;
  localparam logic [7:0] OpReadb  = 8'hc0;
  localparam logic [7:0] OpReadl  = 8'hc1;
  localparam logic [7:0] OpWriteb = 8'hd0;
  localparam logic [7:0] OpWritel = 8'hd1;
  localparam logic [7:0] OpMovsbl = 8'he0;

  // Instruction lengths in bytes; zero marks an unknown opcode.
  localparam logic [2:0] LenBad   = 3'd0;
  localparam logic [2:0] LenOne   = 3'd1;
  localparam logic [2:0] LenReg   = 3'd2;
  localparam logic [2:0] LenJump  = 3'd5;
  localparam logic [2:0] LenLong  = 3'd6;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusInvalid   = 2'd1,
    StatusTruncated = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [31:0] instr_address;
    logic [7:0]  opcode;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [31:0] constant;
    logic [2:0]  length;
    status_e     status;
  } out_t;

  // Length of the instruction that starts with the given opcode.
  function automatic logic [2:0] instr_len(input logic [7:0] op);
    logic [2:0] len;
    unique case (op) inside
      OpNop, OpHalt, OpRet: len = LenOne;
      OpRrmovl, OpAddl, OpSubl, OpAndl, OpXorl, OpAlu4, OpAlu5,
      OpPushl, OpPopl: len = LenReg;
      OpJmp, OpJle, OpJl, OpJe, OpJne, OpJge, OpJg, OpCall: len = LenJump;
      OpIrmovl, OpRmmovl, OpMrmovl, OpReadb, OpReadl, OpWriteb,
      OpWritel, OpMovsbl: len = LenLong;
      default: len = LenBad;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/y86_isd_decoder.sv
module y86_isd_decoder
  import y86_isd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        consume_i,
  input  in_t         item_i,
  output logic        res_valid_o,
  output out_t        res_o
);

  logic [31:0] start_q, start_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] first_q, first_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  op_q, op_d;
  logic [7:0]  reg_q, reg_d;
  logic [31:0] acc_q, acc_d;
  logic        stopped_q, stopped_d;

  logic [31:0] w_first;
  logic [7:0]  w_op;
  logic [7:0]  w_reg;
  logic [31:0] w_acc;
  logic [2:0]  held_len;
  logic [2:0]  new_len;
  logic [2:0]  pos_inc;
  logic [2:0]  shift_pos;
  logic [1:0]  shift_idx;

  // Merge the incoming byte into the instruction being assembled.
  always_comb begin
    held_len  = instr_len(op_q);
    pos_inc   = pos_q + 3'd1;
    w_first   = first_q;
    w_op      = op_q;
    w_reg     = reg_q;
    w_acc     = acc_q;
    shift_pos = (held_len == LenJump) ? (pos_q - 3'd1) : (pos_q - 3'd2);
    shift_idx = shift_pos[1:0];
    if (pos_q == 3'd0) begin
      w_first = cur_q;
      w_op    = item_i.code_byte;
      w_reg   = 8'h00;
      w_acc   = 32'h0;
    end else if (held_len != LenJump && pos_q == 3'd1) begin
      w_reg = item_i.code_byte;
    end else begin
      w_acc = acc_q | (32'(item_i.code_byte) << {shift_idx, 3'b000});
    end
    new_len = instr_len(w_op);
  end

  // Result selection and next state.
  always_comb begin
    start_d     = start_q;
    cur_d       = cur_q;
    first_d     = first_q;
    pos_d       = pos_q;
    op_d        = op_q;
    reg_d       = reg_q;
    acc_d       = acc_q;
    stopped_d   = stopped_q;
    res_valid_o = 1'b0;

    res_o.instr_address = w_first;
    res_o.opcode        = w_op;
    res_o.reg_a         = w_reg[7:4];
    res_o.reg_b         = w_reg[3:0];
    res_o.constant      = w_acc;
    res_o.length        = new_len;
    res_o.status        = StatusOk;

    if (cfg_we_i) begin
      // A new start address drops any partial instruction.
      start_d = cfg_data_i;
      cur_d   = cfg_data_i;
      pos_d   = 3'd0;
      op_d    = 8'h00;
      reg_d   = 8'h00;
      acc_d   = 32'h0;
    end else if (consume_i && !stopped_q) begin
      first_d = w_first;
      op_d    = w_op;
      reg_d   = w_reg;
      acc_d   = w_acc;
      pos_d   = pos_inc;
      cur_d   = cur_q + 32'd1;
      if (new_len == LenBad) begin
        // Unknown opcode: report it and stop until reset.
        res_valid_o  = 1'b1;
        res_o.length = LenOne;
        res_o.status = StatusInvalid;
        stopped_d    = 1'b1;
        pos_d        = 3'd0;
        op_d         = 8'h00;
        reg_d        = 8'h00;
        acc_d        = 32'h0;
      end else begin
        if (pos_inc >= new_len) begin
          res_valid_o = 1'b1;
          pos_d       = 3'd0;
          op_d        = 8'h00;
          reg_d       = 8'h00;
          acc_d       = 32'h0;
        end else if (item_i.end_of_text) begin
          res_valid_o  = 1'b1;
          res_o.length = pos_inc;
          res_o.status = StatusTruncated;
        end
        if (item_i.end_of_text) begin
          // The next byte starts a fresh text at the start address.
          pos_d = 3'd0;
          op_d  = 8'h00;
          reg_d = 8'h00;
          acc_d = 32'h0;
          cur_d = start_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= 32'h0;
      cur_q     <= 32'h0;
      first_q   <= 32'h0;
      pos_q     <= 3'd0;
      op_q      <= 8'h00;
      reg_q     <= 8'h00;
      acc_q     <= 32'h0;
      stopped_q <= 1'b0;
    end else begin
      start_q   <= start_d;
      cur_q     <= cur_d;
      first_q   <= first_d;
      pos_q     <= pos_d;
      op_q      <= op_d;
      reg_q     <= reg_d;
      acc_q     <= acc_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

### hw/rtl/y86_instruction_stream_decoder.sv
// Byte-stream decoder for an extended Y86 instruction set. One program byte is
// taken per beat and the block sustains one byte per clock cycle while the result
// side keeps up; a decoded instruction is offered on the output once its last
// byte has passed through an input register, the combinational decode logic and
// a result register. The input stalls only while both registers hold a beat that
// the result side has not yet taken. An instruction yields one result beat when
// complete, when cut short by end of text (status truncated), or when its opcode
// is unknown (status invalid, after which all bytes are swallowed until reset).
// Writing the start address reloads the fetch address and drops any partial
// instruction; write it only while the block is idle.
module y86_instruction_stream_decoder
  import y86_isd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  out_t out_data_q;
  logic out_free;
  logic consume;
  logic res_valid;
  out_t res;

  // The decode stage moves on whenever the result register can take a beat.
  assign out_free   = !out_valid_q || out_ready_i;
  assign consume    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || consume;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  y86_isd_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .consume_i   (consume),
    .item_i      (in_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= consume && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
